[hdl/cpot_pkg.sv]
// shared types and widths for the closest point on triangle pipeline
// no dependencies; used by cpot_mul, cpot_div and closest_point_on_triangle
package cpot_pkg;

  // coordinate and derived arithmetic widths
  localparam int COORD_BITS = 24;
  localparam int DIST_BITS  = 50;
  localparam int DIF_W      = COORD_BITS + 1;
  localparam int PRD_W      = 2 * DIF_W;
  localparam int DOT_W      = PRD_W + 2;
  localparam int EDG_W      = DOT_W + 1;
  localparam int VOL_W      = 2 * DOT_W;
  localparam int DEN_W      = VOL_W + 2;
  localparam int NUM_W      = DIF_W + VOL_W + 2;

  // wide multiplier: operands cut into chunks of CH_W bits
  localparam int CH_W    = 27;
  localparam int MA_W    = 2 * CH_W;
  localparam int MB_W    = 4 * CH_W;
  localparam int ROW_W   = 5 * CH_W;
  localparam int PROD_W  = NUM_W;
  localparam int MUL_LAT = 4;

  // divider: quotient magnitude bits, saturated beyond
  localparam int QUO_BITS = COORD_BITS + 1;
  localparam int QS_W     = QUO_BITS + 2;
  localparam int DIV_LAT  = QUO_BITS + 2;

  // in, diff, product, dot, volume, classify, numerator, near, square, out
  localparam int PIPE_DEPTH = 10 + 2 * MUL_LAT + DIV_LAT;

  localparam logic signed [COORD_BITS-1:0] CRD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] CRD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [DIF_W-1:0]      dif_t;
  typedef logic signed [PRD_W-1:0]      prd_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [EDG_W-1:0]      edg_t;
  typedef logic signed [VOL_W-1:0]      vol_t;
  typedef logic signed [DEN_W-1:0]      den_t;
  typedef logic signed [NUM_W-1:0]      num_t;
  typedef logic signed [QS_W-1:0]       quo_t;

  typedef enum logic [2:0] {
    RG_VERT_A   = 3'd0,
    RG_VERT_B   = 3'd1,
    RG_EDGE_AB  = 3'd2,
    RG_VERT_C   = 3'd3,
    RG_EDGE_AC  = 3'd4,
    RG_EDGE_BC  = 3'd5,
    RG_INTERIOR = 3'd6
  } region_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
    logic signed [COORD_BITS-1:0] vert_a_x;
    logic signed [COORD_BITS-1:0] vert_a_y;
    logic signed [COORD_BITS-1:0] vert_a_z;
    logic signed [COORD_BITS-1:0] vert_b_x;
    logic signed [COORD_BITS-1:0] vert_b_y;
    logic signed [COORD_BITS-1:0] vert_b_z;
    logic signed [COORD_BITS-1:0] vert_c_x;
    logic signed [COORD_BITS-1:0] vert_c_y;
    logic signed [COORD_BITS-1:0] vert_c_z;
  } in_pkt_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    logic signed [COORD_BITS-1:0] near_z;
    logic [2:0]                   region;
    logic [DIST_BITS-1:0]         dist_squared;
    logic                         degenerate;
  } out_pkt_t;

  // triangle geometry carried down the front of the pipe
  typedef struct packed {
    logic [2:0][COORD_BITS-1:0] p;
    logic [2:0][COORD_BITS-1:0] a;
    logic [2:0][COORD_BITS-1:0] b;
    logic [2:0][COORD_BITS-1:0] c;
    logic [2:0][DIF_W-1:0]      ab;
    logic [2:0][DIF_W-1:0]      ac;
    logic [2:0][DIF_W-1:0]      bc;
  } geo_t;

  // classification result carried down the back of the pipe
  typedef struct packed {
    region_t                    region;
    logic                       degen;
    logic                       use_base;
    logic [2:0][COORD_BITS-1:0] base;
    logic [2:0][COORD_BITS-1:0] p;
    logic [DEN_W-1:0]           den;
  } cls_t;

endpackage

[hdl/closest_point_on_triangle.sv]
// closest point on a triangle: region classification, lerp and distance
// depends on cpot_pkg, cpot_mul and cpot_div
//
//   channel | ports                          | moves
//   input   | in_valid, in_stall, in_pkt     | query point and three vertices
//   output  | out_valid, out_stall, out_pkt  | nearest point, region, distance
//
// one triangle enters every cycle unless the output stalls; the pipe depth
// PIPE_DEPTH is set by the two four-stage wide multiplier banks and the 27-stage divider.
// reset clears only the valid bits of the pipe.
// a stall on the output freezes the whole pipe, so in_stall follows it while
// the last stage holds a transaction; nothing is lost or repeated.
module closest_point_on_triangle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpot_pkg::in_pkt_t  in_pkt,
  output logic               out_valid,
  input  logic               out_stall,
  output cpot_pkg::out_pkt_t out_pkt
);
  import cpot_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  en;

  // global advance
  assign en       = !(vld_r[PIPE_DEPTH-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // stage 0: input register
  in_pkt_t in_r;
  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_pkt;
    end
  end

  // stage 1: edge and offset vectors
  crd_t p0 [3], a0 [3], b0 [3], c0 [3];
  dif_t ap_c [3], bp_c [3], cp_c [3];
  geo_t g1_nxt, g1_r;
  dif_t ap1_r [3], bp1_r [3], cp1_r [3];

  always_comb begin
    p0[0] = in_r.query_x;  p0[1] = in_r.query_y;  p0[2] = in_r.query_z;
    a0[0] = in_r.vert_a_x; a0[1] = in_r.vert_a_y; a0[2] = in_r.vert_a_z;
    b0[0] = in_r.vert_b_x; b0[1] = in_r.vert_b_y; b0[2] = in_r.vert_b_z;
    c0[0] = in_r.vert_c_x; c0[1] = in_r.vert_c_y; c0[2] = in_r.vert_c_z;
    for (int k = 0; k < 3; k++) begin
      g1_nxt.p[k]  = p0[k];
      g1_nxt.a[k]  = a0[k];
      g1_nxt.b[k]  = b0[k];
      g1_nxt.c[k]  = c0[k];
      g1_nxt.ab[k] = DIF_W'(b0[k]) - DIF_W'(a0[k]);
      g1_nxt.ac[k] = DIF_W'(c0[k]) - DIF_W'(a0[k]);
      g1_nxt.bc[k] = DIF_W'(c0[k]) - DIF_W'(b0[k]);
      ap_c[k] = DIF_W'(p0[k]) - DIF_W'(a0[k]);
      bp_c[k] = DIF_W'(p0[k]) - DIF_W'(b0[k]);
      cp_c[k] = DIF_W'(p0[k]) - DIF_W'(c0[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r  <= g1_nxt;
      ap1_r <= ap_c;
      bp1_r <= bp_c;
      cp1_r <= cp_c;
    end
  end

  // stage 2: the eighteen coordinate products
  dif_t ab1 [3], ac1 [3];
  prd_t pr_c [6][3];
  prd_t pr2_r [6][3];
  geo_t g2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab1[k] = g1_r.ab[k];
      ac1[k] = g1_r.ac[k];
      pr_c[0][k] = PRD_W'(ab1[k]) * PRD_W'(ap1_r[k]);
      pr_c[1][k] = PRD_W'(ac1[k]) * PRD_W'(ap1_r[k]);
      pr_c[2][k] = PRD_W'(ab1[k]) * PRD_W'(bp1_r[k]);
      pr_c[3][k] = PRD_W'(ac1[k]) * PRD_W'(bp1_r[k]);
      pr_c[4][k] = PRD_W'(ab1[k]) * PRD_W'(cp1_r[k]);
      pr_c[5][k] = PRD_W'(ac1[k]) * PRD_W'(cp1_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr2_r <= pr_c;
      g2_r  <= g1_r;
    end
  end

  // stage 3: dot products d1 to d6
  dot_t dd_c [6];
  dot_t dd3_r [6];
  geo_t g3_r;

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      dd_c[j] = DOT_W'(pr2_r[j][0]) + DOT_W'(pr2_r[j][1]) + DOT_W'(pr2_r[j][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd3_r <= dd_c;
      g3_r  <= g2_r;
    end
  end

  // barycentric cross products in the first multiplier bank
  logic signed [PROD_W-1:0] mv [6];

  cpot_mul u_mul_vc1 (.clk(clk), .en(en), .a(MA_W'(dd3_r[0])), .b(MB_W'(dd3_r[3])), .p(mv[0]));
  cpot_mul u_mul_vc2 (.clk(clk), .en(en), .a(MA_W'(dd3_r[2])), .b(MB_W'(dd3_r[1])), .p(mv[1]));
  cpot_mul u_mul_vb1 (.clk(clk), .en(en), .a(MA_W'(dd3_r[4])), .b(MB_W'(dd3_r[1])), .p(mv[2]));
  cpot_mul u_mul_vb2 (.clk(clk), .en(en), .a(MA_W'(dd3_r[0])), .b(MB_W'(dd3_r[5])), .p(mv[3]));
  cpot_mul u_mul_va1 (.clk(clk), .en(en), .a(MA_W'(dd3_r[2])), .b(MB_W'(dd3_r[5])), .p(mv[4]));
  cpot_mul u_mul_va2 (.clk(clk), .en(en), .a(MA_W'(dd3_r[4])), .b(MB_W'(dd3_r[3])), .p(mv[5]));

  geo_t gm_r  [MUL_LAT];
  dot_t ddm_r [MUL_LAT][6];

  always_ff @(posedge clk) begin
    if (en) begin
      gm_r[0]  <= g3_r;
      ddm_r[0] <= dd3_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        gm_r[i]  <= gm_r[i-1];
        ddm_r[i] <= ddm_r[i-1];
      end
    end
  end

  // volume stage: va, vb, vc and the edge terms for BC
  geo_t g4_r;
  dot_t dd4_r [6];
  vol_t va_r, vb_r, vc_r;
  edg_t e1_r, e2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g4_r  <= gm_r[MUL_LAT-1];
      dd4_r <= ddm_r[MUL_LAT-1];
      vc_r  <= VOL_W'(mv[0] - mv[1]);
      vb_r  <= VOL_W'(mv[2] - mv[3]);
      va_r  <= VOL_W'(mv[4] - mv[5]);
      e1_r  <= EDG_W'(ddm_r[MUL_LAT-1][3]) - EDG_W'(ddm_r[MUL_LAT-1][2]);
      e2_r  <= EDG_W'(ddm_r[MUL_LAT-1][4]) - EDG_W'(ddm_r[MUL_LAT-1][5]);
    end
  end

  // classify stage: regions tested in priority order
  den_t den_int_c, den_c;
  cls_t cl_nxt, cl_r;
  dif_t x_nxt [3], u_nxt [3], x_r [3], u_r [3];
  vol_t y_nxt, w_nxt, y_r, w_r;
  logic vert_c;

  always_comb begin
    den_int_c = DEN_W'(va_r) + DEN_W'(vb_r) + DEN_W'(vc_r);
    cl_nxt.p     = g4_r.p;
    cl_nxt.degen = 1'b0;
    cl_nxt.base  = g4_r.a;
    vert_c       = 1'b0;
    den_c        = den_int_c;
    y_nxt        = '0;
    w_nxt        = '0;
    for (int k = 0; k < 3; k++) begin
      x_nxt[k] = g4_r.ab[k];
      u_nxt[k] = '0;
    end
    priority if (dd4_r[0] <= 0 && dd4_r[1] <= 0) begin
      cl_nxt.region = RG_VERT_A;
      vert_c        = 1'b1;
    end else if (dd4_r[2] >= 0 && dd4_r[2] >= dd4_r[3]) begin
      cl_nxt.region = RG_VERT_B;
      cl_nxt.base   = g4_r.b;
      vert_c        = 1'b1;
    end else if (vc_r <= 0 && dd4_r[0] >= 0 && dd4_r[2] <= 0) begin
      cl_nxt.region = RG_EDGE_AB;
      y_nxt         = VOL_W'(dd4_r[0]);
      den_c         = DEN_W'(dd4_r[0]) - DEN_W'(dd4_r[2]);
    end else if (dd4_r[5] >= 0 && dd4_r[5] >= dd4_r[4]) begin
      cl_nxt.region = RG_VERT_C;
      cl_nxt.base   = g4_r.c;
      vert_c        = 1'b1;
    end else if (vb_r <= 0 && dd4_r[1] >= 0 && dd4_r[5] <= 0) begin
      cl_nxt.region = RG_EDGE_AC;
      for (int k = 0; k < 3; k++) x_nxt[k] = g4_r.ac[k];
      y_nxt         = VOL_W'(dd4_r[1]);
      den_c         = DEN_W'(dd4_r[1]) - DEN_W'(dd4_r[5]);
    end else if (va_r <= 0 && e1_r >= 0 && e2_r >= 0) begin
      cl_nxt.region = RG_EDGE_BC;
      cl_nxt.base   = g4_r.b;
      for (int k = 0; k < 3; k++) x_nxt[k] = g4_r.bc[k];
      y_nxt         = VOL_W'(e1_r);
      den_c         = DEN_W'(e1_r) + DEN_W'(e2_r);
    end else begin
      cl_nxt.region = RG_INTERIOR;
      cl_nxt.degen  = (den_int_c == 0);
      for (int k = 0; k < 3; k++) u_nxt[k] = g4_r.ac[k];
      y_nxt         = vb_r;
      w_nxt         = vc_r;
    end
    cl_nxt.den      = den_c;
    cl_nxt.use_base = vert_c || (den_c == 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl_r <= cl_nxt;
      x_r  <= x_nxt;
      u_r  <= u_nxt;
      y_r  <= y_nxt;
      w_r  <= w_nxt;
    end
  end

  // numerator products in the second multiplier bank
  logic signed [PROD_W-1:0] nx [3], nu [3];

  for (genvar k = 0; k < 3; k++) begin : g_num_mul
    cpot_mul u_mul_x (.clk(clk), .en(en), .a(MA_W'(x_r[k])), .b(MB_W'(y_r)), .p(nx[k]));
    cpot_mul u_mul_u (.clk(clk), .en(en), .a(MA_W'(u_r[k])), .b(MB_W'(w_r)), .p(nu[k]));
  end

  cls_t clm_r [MUL_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      clm_r[0] <= cl_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        clm_r[i] <= clm_r[i-1];
      end
    end
  end

  // numerator stage
  num_t num_r [3];
  cls_t cln_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= NUM_W'(nx[k] + nu[k]);
      end
      cln_r <= clm_r[MUL_LAT-1];
    end
  end

  // three dividers, one per coordinate
  quo_t qv [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    cpot_div u_div (.clk(clk), .en(en), .num(num_r[k]), .den($signed(cln_r.den)), .q(qv[k]));
  end

  cls_t cld_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      cld_r[0] <= cln_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        cld_r[i] <= cld_r[i-1];
      end
    end
  end

  // near stage: the base alone when use_base is set, else base plus offset, clamped to the coordinate range
  logic [2:0][COORD_BITS-1:0] nr_c, nr_r;
  cls_t cle_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd_t                  bs;
      logic signed [QS_W:0]  s;
      bs = cld_r[DIV_LAT-1].base[k];
      s  = (QS_W+1)'(bs) + (QS_W+1)'(qv[k]);
      if (cld_r[DIV_LAT-1].use_base) begin
        nr_c[k] = bs;
      end else if (s < (QS_W+1)'(CRD_MIN)) begin
        nr_c[k] = CRD_MIN;
      end else if (s > (QS_W+1)'(CRD_MAX)) begin
        nr_c[k] = CRD_MAX;
      end else begin
        nr_c[k] = COORD_BITS'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nr_r  <= nr_c;
      cle_r <= cld_r[DIV_LAT-1];
    end
  end

  // square stage
  logic [PRD_W-1:0] sq_c [3], sq_r [3];
  logic [2:0][COORD_BITS-1:0] nr2_r;
  cls_t cls_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd_t pc, nc;
      dif_t df;
      prd_t pq;
      pc = cle_r.p[k];
      nc = nr_r[k];
      df = DIF_W'(pc) - DIF_W'(nc);
      pq = PRD_W'(df) * PRD_W'(df);
      sq_c[k] = $unsigned(pq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= sq_c;
      nr2_r <= nr_r;
      cls_r <= cle_r;
    end
  end

  // output register: distance sum with saturation
  logic [PRD_W+1:0] dsum_c;
  out_pkt_t out_nxt, out_r;

  always_comb begin
    dsum_c = (PRD_W+2)'(sq_r[0]) + (PRD_W+2)'(sq_r[1]) + (PRD_W+2)'(sq_r[2]);
    out_nxt.near_x     = nr2_r[0];
    out_nxt.near_y     = nr2_r[1];
    out_nxt.near_z     = nr2_r[2];
    out_nxt.region     = cls_r.region;
    out_nxt.degenerate = cls_r.degen;
    if (|dsum_c[PRD_W+1:DIST_BITS]) begin
      out_nxt.dist_squared = '1;
    end else begin
      out_nxt.dist_squared = dsum_c[DIST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];
  assign out_pkt   = out_r;

endmodule

[hdl/cpot_mul.sv]
// four-stage signed multiplier, operands split into 27-bit chunks
// depends on cpot_pkg for widths
module cpot_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [cpot_pkg::MA_W-1:0]   a,
  input  logic signed [cpot_pkg::MB_W-1:0]   b,
  output logic signed [cpot_pkg::PROD_W-1:0] p
);
  import cpot_pkg::*;

  logic              neg0_r, neg1_r, neg2_r;
  logic [MA_W-1:0]   am_r;
  logic [MB_W-1:0]   bm_r;
  logic [2*CH_W-1:0] pp_r [2][4];
  logic [ROW_W-1:0]  row_nxt [2];
  logic [ROW_W-1:0]  row_r [2];
  logic [PROD_W-1:0] sum_c;
  logic [PROD_W-1:0] p_r;

  // row sums of the partial products
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      row_nxt[j] = '0;
      for (int i = 0; i < 4; i++) begin
        row_nxt[j] = row_nxt[j] + (ROW_W'(pp_r[j][i]) << (CH_W * i));
      end
    end
    sum_c = PROD_W'(row_r[0]) + (PROD_W'(row_r[1]) << CH_W);
  end

  // magnitude, partial products, rows, signed result
  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= a[MA_W-1] ^ b[MB_W-1];
      am_r   <= a[MA_W-1] ? $unsigned(-a) : $unsigned(a);
      bm_r   <= b[MB_W-1] ? $unsigned(-b) : $unsigned(b);
      neg1_r <= neg0_r;
      for (int j = 0; j < 2; j++) begin
        for (int i = 0; i < 4; i++) begin
          pp_r[j][i] <= (2*CH_W)'(am_r[j*CH_W +: CH_W]) * (2*CH_W)'(bm_r[i*CH_W +: CH_W]);
        end
      end
      neg2_r <= neg1_r;
      row_r  <= row_nxt;
      p_r    <= neg2_r ? -sum_c : sum_c;
    end
  end

  assign p = $signed(p_r);

endmodule

[hdl/cpot_div.sv]
// pipelined restoring divider, one quotient bit per stage, round to nearest
// depends on cpot_pkg for widths; quotient saturates beyond QUO_BITS
module cpot_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [cpot_pkg::NUM_W-1:0] num,
  input  logic signed [cpot_pkg::DEN_W-1:0] den,
  output logic signed [cpot_pkg::QS_W-1:0]  q
);
  import cpot_pkg::*;

  logic [NUM_W-1:0]    rem_r [QUO_BITS+1];
  logic [DEN_W-1:0]    dm_r  [QUO_BITS+1];
  logic [QUO_BITS-1:0] qb_r  [QUO_BITS+1];
  logic                neg_r [QUO_BITS+1];
  logic                ovf_r [QUO_BITS+1];
  logic [NUM_W-1:0]    rem_nxt [QUO_BITS];
  logic [QUO_BITS-1:0] qb_nxt  [QUO_BITS];
  logic [NUM_W-1:0]    nabs_c;
  logic [DEN_W-1:0]    dabs_c;
  logic                up_c;
  logic [QUO_BITS:0]   qm_c;
  quo_t                q_r;

  // magnitudes and quotient overflow test
  assign nabs_c = num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
  assign dabs_c = den[DEN_W-1] ? $unsigned(-den) : $unsigned(den);

  // one trial subtraction per stage
  always_comb begin
    for (int i = 0; i < QUO_BITS; i++) begin
      logic [NUM_W-1:0] sh;
      sh = NUM_W'(dm_r[i]) << (QUO_BITS - 1 - i);
      qb_nxt[i] = qb_r[i];
      if (rem_r[i] >= sh) begin
        rem_nxt[i] = rem_r[i] - sh;
        qb_nxt[i][QUO_BITS-1-i] = 1'b1;
      end else begin
        rem_nxt[i] = rem_r[i];
      end
    end
  end

  // rounding: half the divisor or more rounds the magnitude up
  always_comb begin
    up_c = {rem_r[QUO_BITS][DEN_W-1:0], 1'b0} >= {1'b0, dm_r[QUO_BITS]};
    if (ovf_r[QUO_BITS]) begin
      qm_c = {1'b0, {QUO_BITS{1'b1}}};
    end else begin
      qm_c = (QUO_BITS+1)'(qb_r[QUO_BITS]) + (QUO_BITS+1)'(up_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= nabs_c;
      dm_r[0]  <= dabs_c;
      qb_r[0]  <= '0;
      neg_r[0] <= num[NUM_W-1] ^ den[DEN_W-1];
      ovf_r[0] <= nabs_c >= (NUM_W'(dabs_c) << QUO_BITS);
      for (int i = 0; i < QUO_BITS; i++) begin
        rem_r[i+1] <= rem_nxt[i];
        qb_r[i+1]  <= qb_nxt[i];
        dm_r[i+1]  <= dm_r[i];
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
      q_r <= neg_r[QUO_BITS] ? -$signed({1'b0, qm_c}) : $signed({1'b0, qm_c});
    end
  end

  assign q = q_r;

endmodule
